// ===== hdl/hprc_pkg.sv =====
// Shared types and constants for the homopolymer run compressor.
// No dependencies; every hprc module imports this package.
`timescale 1ns / 1ps

package hprc_pkg;

    localparam int MAX_READ_LEN = 4096;

    localparam int BASE_W = 8;
    localparam int QUAL_W = 7;
    localparam int FRAC_W = 8;
    localparam int MEAN_W = 15;
    localparam int LEN_W  = $clog2(MAX_READ_LEN + 1);
    localparam int POS_W  = $clog2(MAX_READ_LEN);
    localparam int SUM_W  = $clog2(MAX_READ_LEN * ((1 << QUAL_W) - 1) + 1);
    localparam int DVD_W  = SUM_W + FRAC_W;
    localparam int STEP_W = $clog2(MEAN_W + 1);

    // Run queue between tracker and divider
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QLVL_W = $clog2(QDEPTH + 1);

    // Largest possible mean: every quality at its maximum
    localparam int MEAN_MAX = ((1 << QUAL_W) - 1) << FRAC_W;

    typedef struct packed {
        logic [BASE_W-1:0] letter;
        logic [LEN_W-1:0]  length;
        logic [POS_W-1:0]  start;
        logic [SUM_W-1:0]  sum;
        logic              last;
    } run_rec_t;

    typedef struct packed {
        logic push_a;
        logic push_b;
    } push_t;

    typedef struct packed {
        logic              nonempty;
        logic              almost_full;
        logic [QLVL_W-1:0] level;
    } q_stat_t;

endpackage

// ===== hdl/hprc_front.sv =====
// Run tracker: accepts bases, groups equal letters into runs and pushes
// finished runs to the queue. Depends on hprc_pkg.
`timescale 1ns / 1ps

module hprc_front
    import hprc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BASE_W-1:0] base,
    input  logic [QUAL_W-1:0] quality,
    input  logic              end_of_read,
    output push_t             push,
    output run_rec_t          rec_a,
    output run_rec_t          rec_b
);

    logic              in_read_reg, in_read_next;
    logic [BASE_W-1:0] letter_reg, letter_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [POS_W-1:0]  start_reg, start_next;
    logic [POS_W-1:0]  pos_reg, pos_next;

    always_comb
    begin
        in_read_next = in_read_reg;
        letter_next  = letter_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        start_next   = start_reg;
        pos_next     = pos_reg;
        push         = '{push_a: 1'b0, push_b: 1'b0};
        rec_a        = '{letter_reg, count_reg, start_reg, sum_reg, 1'b0};

        if (accept)
        begin
            if (!in_read_reg)
            begin
                pos_next     = '0;
                letter_next  = base;
                count_next   = LEN_W'(1);
                sum_next     = SUM_W'(quality);
                start_next   = '0;
                in_read_next = 1'b1;
            end
            else
            begin
                if (pos_reg < POS_W'(MAX_READ_LEN - 1))
                    pos_next = pos_reg + 1'b1;
                if (base == letter_reg)
                begin
                    // saturate: drop bases beyond the bound
                    if (count_reg < LEN_W'(MAX_READ_LEN))
                    begin
                        count_next = count_reg + 1'b1;
                        sum_next   = sum_reg + SUM_W'(quality);
                    end
                end
                else
                begin
                    push.push_a = 1'b1;
                    letter_next = base;
                    count_next  = LEN_W'(1);
                    sum_next    = SUM_W'(quality);
                    start_next  = pos_next;
                end
            end

            if (end_of_read)
            begin
                push.push_b  = 1'b1;
                in_read_next = 1'b0;
                pos_next     = '0;
            end
        end

        rec_b = '{letter_next, count_next, start_next, sum_next, 1'b1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_read_reg <= 1'b0;
            letter_reg  <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            start_reg   <= '0;
            pos_reg     <= '0;
        end
        else
        begin
            in_read_reg <= in_read_next;
            letter_reg  <= letter_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            start_reg   <= start_next;
            pos_reg     <= pos_next;
        end
    end

endmodule

// ===== hdl/hprc_queue.sv =====
// Short run queue: up to two pushes and one pop per cycle.
// Depends on hprc_pkg.
`timescale 1ns / 1ps

module hprc_queue
    import hprc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  push_t    push,
    input  run_rec_t rec_a,
    input  run_rec_t rec_b,
    input  logic     pop,
    output run_rec_t head,
    output q_stat_t  stat
);

    run_rec_t          entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QLVL_W-1:0] level_reg, level_next;
    logic [QPTR_W-1:0] b_ptr;
    logic [1:0]        n_push;

    assign n_push = {1'b0, push.push_a} + {1'b0, push.push_b};
    assign b_ptr  = push.push_a ? wr_ptr_reg + 1'b1 : wr_ptr_reg;

    assign wr_ptr_next = wr_ptr_reg + QPTR_W'(n_push);
    assign rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
    assign level_next  = level_reg + QLVL_W'(n_push) - QLVL_W'(pop);

    assign head             = entry_reg[rd_ptr_reg];
    assign stat.nonempty    = (level_reg != '0);
    // hold the input while fewer than two slots are free
    assign stat.almost_full = (level_reg > QLVL_W'(QDEPTH - 2));
    assign stat.level       = level_reg;

    always_ff @(posedge clk)
    begin
        if (push.push_a)
            entry_reg[wr_ptr_reg] <= rec_a;
        if (push.push_b)
            entry_reg[b_ptr] <= rec_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

// ===== hdl/hprc_back.sv =====
// Run finisher: pops a run, computes the mean quality with a restoring
// divider (one quotient bit per cycle) and holds the result item.
// Depends on hprc_pkg.
`timescale 1ns / 1ps

module hprc_back
    import hprc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  run_rec_t          head,
    input  q_stat_t           stat,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BASE_W-1:0] run_base,
    output logic [LEN_W-1:0]  run_length,
    output logic [POS_W-1:0]  run_start,
    output logic [MEAN_W-1:0] mean_quality,
    output logic              read_last
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [MEAN_W-1:0] qd_reg, qd_next;
    logic [LEN_W-1:0]  div_reg;
    logic [BASE_W-1:0] letter_reg;
    logic [POS_W-1:0]  start_reg;
    logic              last_reg;
    logic              valid_reg, valid_next;
    logic [BASE_W-1:0] ob_reg;
    logic [LEN_W-1:0]  ol_reg;
    logic [POS_W-1:0]  os_reg;
    logic [MEAN_W-1:0] om_reg;
    logic              olast_reg;

    logic [DVD_W-1:0]  dvd;
    logic [LEN_W:0]    trial;
    logic              ge;
    logic              div_done;
    logic              out_free;
    logic              load_out;

    assign dvd      = {head.sum, {FRAC_W{1'b0}}};
    assign trial    = {rem_reg, qd_reg[MEAN_W-1]};
    assign ge       = (trial >= {1'b0, div_reg});
    assign div_done = busy_reg && (step_reg == STEP_W'(MEAN_W));
    assign out_free = !valid_reg || !out_stall;
    assign load_out = div_done && out_free;
    assign pop      = !busy_reg && stat.nonempty;

    always_comb
    begin
        busy_next  = busy_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        qd_next    = qd_reg;
        valid_next = valid_reg && out_stall;

        if (pop)
        begin
            busy_next = 1'b1;
            step_next = '0;
            // upper dividend bits are below the divisor: the quotient fits MEAN_W
            rem_next  = LEN_W'(dvd >> MEAN_W);
            qd_next   = dvd[MEAN_W-1:0];
        end
        else if (busy_reg && !div_done)
        begin
            step_next = step_reg + 1'b1;
            rem_next  = ge ? LEN_W'(trial - {1'b0, div_reg}) : trial[LEN_W-1:0];
            qd_next   = {qd_reg[MEAN_W-2:0], ge};
        end
        else if (load_out)
        begin
            busy_next  = 1'b0;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            div_reg    <= head.length;
            letter_reg <= head.letter;
            start_reg  <= head.start;
            last_reg   <= head.last;
        end
        if (load_out)
        begin
            ob_reg    <= letter_reg;
            ol_reg    <= div_reg;
            os_reg    <= start_reg;
            om_reg    <= qd_reg;
            olast_reg <= last_reg;
        end
        rem_reg <= rem_next;
        qd_reg  <= qd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid    = valid_reg;
    assign run_base     = ob_reg;
    assign run_length   = ol_reg;
    assign run_start    = os_reg;
    assign mean_quality = om_reg;
    assign read_last    = olast_reg;

endmodule

// ===== hdl/homopolymer_run_compressor.sv =====
// Homopolymer run compressor: one base per item in, one item per finished run out.
// Throughput: one base per cycle while the run queue has two free slots; runs pass
// through the divider one at a time (pop, 15 quotient bits, output load once the
// output register is free).
// Reset: asynchronous, active low; clears the open run, the queue and the output.
`timescale 1ns / 1ps

module homopolymer_run_compressor
    import hprc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BASE_W-1:0] base,
    input  logic [QUAL_W-1:0] quality,
    input  logic              end_of_read,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BASE_W-1:0] run_base,
    output logic [LEN_W-1:0]  run_length,
    output logic [POS_W-1:0]  run_start,
    output logic [MEAN_W-1:0] mean_quality,
    output logic              read_last
);

    push_t    push;
    run_rec_t rec_a;
    run_rec_t rec_b;
    run_rec_t head;
    q_stat_t  stat;
    logic     pop;
    logic     accept;

    assign in_stall = stat.almost_full;
    assign accept   = in_valid && !in_stall;

    hprc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .base        (base),
        .quality     (quality),
        .end_of_read (end_of_read),
        .push        (push),
        .rec_a       (rec_a),
        .rec_b       (rec_b)
    );

    hprc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .rec_a (rec_a),
        .rec_b (rec_b),
        .pop   (pop),
        .head  (head),
        .stat  (stat)
    );

    hprc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .stat         (stat),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .run_base     (run_base),
        .run_length   (run_length),
        .run_start    (run_start),
        .mean_quality (mean_quality),
        .read_last    (read_last)
    );

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.level <= QLVL_W'(QDEPTH))
        else $error("run queue level beyond its depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> stat.level != '0)
        else $error("pop from empty run queue");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> run_length != '0)
        else $error("result item with empty run");

    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> mean_quality <= MEAN_W'(MEAN_MAX))
        else $error("mean quality above largest quality");
`endif

endmodule

// ===== tb/sv/homopolymer_run_compressor_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for homopolymer_run_compressor: a directed script, then random reads.
// Predicts every run item as bases are accepted and checks results in order; needs hprc_pkg.

module homopolymer_run_compressor_tb;
    import hprc_pkg::*;

    localparam int RANDOM_ITEMS    = 1032;
    localparam int GAP_PCT         = 23;
    localparam int QUIET_FIRST     = 400;
    localparam int QUIET_LAST      = 600;
    localparam int PRESSURE_AT     = 150;
    localparam int PRESSURE_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 40;

    localparam logic [BASE_W-1:0] LETTER_A = 8'h41;
    localparam logic [BASE_W-1:0] LETTER_C = 8'h43;
    localparam logic [BASE_W-1:0] LETTER_G = 8'h47;
    localparam logic [BASE_W-1:0] LETTER_T = 8'h54;
    localparam logic [BASE_W-1:0] NUCLEOTIDES [4] = '{LETTER_A, LETTER_C, LETTER_G, LETTER_T};

    typedef struct packed {
        logic [BASE_W-1:0] letter;
        logic [LEN_W-1:0]  length;
        logic [POS_W-1:0]  start;
        logic [MEAN_W-1:0] mean;
        logic              last;
    } run_t;

    typedef struct packed {
        logic [BASE_W-1:0] letter;
        logic [QUAL_W-1:0] qual;
        logic              eor;
        logic [LEN_W-1:0]  reps;
        logic              has_exp;
        run_t              exp_run;
    } script_row_t;

    localparam int SCRIPT_ROWS = 13;
    localparam run_t NO_RUN = '0;

    // Typed expectations apply to the last run item of the row's final base.
    localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
        // single-base reads: lowest, highest and nominal top quality
        '{LETTER_A, 7'd0,   1'b1, 13'd1, 1'b1, '{LETTER_A, 13'd1, 12'd0, 15'd0,     1'b1}},
        '{8'hFF,    7'd127, 1'b1, 13'd1, 1'b1, '{8'hFF,    13'd1, 12'd0, 15'd32512, 1'b1}},
        '{8'h00,    7'd93,  1'b1, 13'd1, 1'b1, '{8'h00,    13'd1, 12'd0, 15'd23808, 1'b1}},
        // letter change and end of read on the same base
        '{LETTER_A, 7'd10,  1'b0, 13'd1, 1'b0, NO_RUN},
        '{LETTER_A, 7'd20,  1'b0, 13'd1, 1'b0, NO_RUN},
        '{LETTER_C, 7'd30,  1'b1, 13'd1, 1'b1, '{LETTER_C, 13'd1, 12'd2, 15'd7680,  1'b1}},
        // truncated mean
        '{LETTER_T, 7'd1,   1'b0, 13'd1, 1'b0, NO_RUN},
        '{LETTER_T, 7'd2,   1'b0, 13'd1, 1'b0, NO_RUN},
        '{LETTER_T, 7'd4,   1'b1, 13'd1, 1'b0, NO_RUN},
        // a new letter on every base
        '{LETTER_A, 7'd93,  1'b0, 13'd1, 1'b0, NO_RUN},
        '{LETTER_C, 7'd0,   1'b0, 13'd1, 1'b0, NO_RUN},
        '{LETTER_A, 7'd93,  1'b0, 13'd1, 1'b0, NO_RUN},
        '{LETTER_C, 7'd50,  1'b1, 13'd1, 1'b0, NO_RUN}
    };

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [BASE_W-1:0] base;
    logic [QUAL_W-1:0] quality;
    logic              end_of_read;
    logic              out_valid;
    logic              out_stall;
    logic [BASE_W-1:0] run_base;
    logic [LEN_W-1:0]  run_length;
    logic [POS_W-1:0]  run_start;
    logic [MEAN_W-1:0] mean_quality;
    logic              read_last;

    // Predicted state of the open run
    logic              in_read;
    logic [BASE_W-1:0] open_letter;
    logic [LEN_W-1:0]  open_count;
    logic [SUM_W-1:0]  open_qsum;
    logic [POS_W-1:0]  open_start;
    logic [POS_W-1:0]  read_pos;

    run_t pending_runs [$];
    int   errors       = 0;
    int   runs_checked = 0;
    logic no_gaps      = 1'b0;

    homopolymer_run_compressor uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .base         (base),
        .quality      (quality),
        .end_of_read  (end_of_read),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .run_base     (run_base),
        .run_length   (run_length),
        .run_start    (run_start),
        .mean_quality (mean_quality),
        .read_last    (read_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic run_t close_run(input logic last);
        logic [SUM_W+FRAC_W-1:0] scaled;
        run_t r;
        scaled   = {open_qsum, {FRAC_W{1'b0}}};
        r.letter = open_letter;
        r.length = open_count;
        r.start  = open_start;
        r.mean   = MEAN_W'(scaled / open_count);
        r.last   = last;
        return r;
    endfunction

    task automatic track_base(input logic [BASE_W-1:0] b, input logic [QUAL_W-1:0] q,
                              input logic e);
        if (!in_read)
        begin
            read_pos    = '0;
            open_letter = b;
            open_count  = LEN_W'(1);
            open_qsum   = SUM_W'(q);
            open_start  = '0;
            in_read     = 1'b1;
        end
        else
        begin
            if (read_pos < POS_W'(MAX_READ_LEN - 1))
                read_pos = read_pos + 1'b1;
            if (b == open_letter)
            begin
                // stop counting at the bound, qualities included
                if (open_count < LEN_W'(MAX_READ_LEN))
                begin
                    open_count = open_count + 1'b1;
                    open_qsum  = open_qsum + SUM_W'(q);
                end
            end
            else
            begin
                pending_runs = {pending_runs, close_run(1'b0)};
                open_letter = b;
                open_count  = LEN_W'(1);
                open_qsum   = SUM_W'(q);
                open_start  = read_pos;
            end
        end
        if (e)
        begin
            pending_runs = {pending_runs, close_run(1'b1)};
            in_read  = 1'b0;
            read_pos = '0;
        end
    endtask

    task automatic send_base(input logic [BASE_W-1:0] b, input logic [QUAL_W-1:0] q,
                             input logic e);
        @(negedge clk);
        while (!no_gaps && $urandom_range(99) < GAP_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        base        <= b;
        quality     <= q;
        end_of_read <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_base(b, q, e);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Result side: random stall, plus one long hold-off so the run queue fills up
    initial
    begin
        int  hold_left;
        logic pressure_done;
        hold_left     = 0;
        pressure_done = 1'b0;
        out_stall     = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!pressure_done && runs_checked >= PRESSURE_AT)
            begin
                hold_left     = PRESSURE_CYCLES;
                pressure_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !no_gaps && ($urandom_range(99) < GAP_PCT);
        end
    end

    always @(posedge clk)
    begin : check_runs
        run_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_runs.size() == 0)
            begin
                $display("%0t: unexpected run item, expected none, actual base %0h len %0d",
                         $time, run_base, run_length);
                errors++;
            end
            else
            begin
                want = pending_runs.pop_front();
                compare_field("run_base", want.letter, run_base);
                compare_field("run_length", want.length, run_length);
                compare_field("run_start", want.start, run_start);
                compare_field("mean_quality", want.mean, mean_quality);
                compare_field("read_last", want.last, read_last);
            end
            runs_checked++;
        end
    end

    initial
    begin
        logic [BASE_W-1:0] prev_letter;
        logic [BASE_W-1:0] letter;
        logic [QUAL_W-1:0] qual;
        logic              eor;
        int                pick;

        in_valid    = 1'b0;
        base        = '0;
        quality     = '0;
        end_of_read = 1'b0;
        in_read     = 1'b0;
        open_letter = '0;
        open_count  = '0;
        open_qsum   = '0;
        open_start  = '0;
        read_pos    = '0;
        rst_n       = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < SCRIPT_ROWS; r++)
        begin
            for (int k = 0; k < SCRIPT[r].reps; k++)
                send_base(SCRIPT[r].letter, SCRIPT[r].qual, SCRIPT[r].eor);
            if (SCRIPT[r].has_exp)
            begin
                void'(pending_runs.pop_back());
                pending_runs = {pending_runs, SCRIPT[r].exp_run};
            end
        end

        // Mostly nucleotide runs, some arbitrary bytes; reads average about a dozen bases.
        prev_letter = LETTER_A;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_gaps = (i >= QUIET_FIRST && i < QUIET_LAST);
            pick = $urandom_range(99);
            if (pick < 55)
                letter = prev_letter;
            else if (pick < 95)
                letter = NUCLEOTIDES[$urandom_range(3)];
            else
                letter = BASE_W'($urandom_range(255));
            if ($urandom_range(99) < 80)
                qual = QUAL_W'($urandom_range(93));
            else
                qual = QUAL_W'($urandom_range(127));
            eor = ($urandom_range(99) < 8) || (i == RANDOM_ITEMS - 1);
            send_base(letter, qual, eor);
            prev_letter = letter;
        end
        no_gaps = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_runs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("** homopolymer_run_compressor: PASSED **");
        else
            $display("** homopolymer_run_compressor: FAILED **");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("%0t: timeout, %0d run items still expected", $time, pending_runs.size());
        $display("** homopolymer_run_compressor: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/hprc_pkg.sv
hdl/hprc_front.sv
hdl/hprc_queue.sv
hdl/hprc_back.sv
hdl/homopolymer_run_compressor.sv
tb/sv/homopolymer_run_compressor_tb.sv
